@@ sv/bblur3_pkg.sv @@
// Shared types, constants and the reciprocal table for the 3x3 RGB box blur.
// No dependencies; imported by every module of the block.
package bblur3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int HEIGHT_LIMIT   = 4096;
    localparam int ITEM_BITS      = 23;
    localparam int CHAN_BITS      = 8;
    localparam int LANES          = 3;
    localparam int PIX_BITS       = CHAN_BITS * LANES;
    localparam int WIN_TAPS       = 9;
    localparam int COUNT_BITS     = 4;
    localparam int SUM_BITS       = 12;
    localparam int RECIP_BITS     = 16;
    localparam int CFG_DATA_BITS  = HEIGHT_BITS;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    // register indexes of the configuration port
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // control handed from the sequencer to each channel lane
    typedef struct packed {
        logic                  sum_en;
        logic                  out_en;
        logic [WIN_TAPS-1:0]   take;
        logic [COUNT_BITS-1:0] count;
    } lane_ctrl_t;

    // ceil(2^16 / (2n)) for the neighbour counts that can occur; exact for
    // every numerator 2*sum+n that a 3x3 window of bytes gives
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] n);
        logic [RECIP_BITS-1:0] r;
        case (n)
            4'd1:    r = 16'd32768;
            4'd2:    r = 16'd16384;
            4'd3:    r = 16'd10923;
            4'd4:    r = 16'd8192;
            4'd6:    r = 16'd5462;
            4'd9:    r = 16'd3641;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/bblur3_line_store.sv @@
// Two-row line store for the box blur: one word per column holds the upper
// and middle rows. Registered read with write-first bypass. Uses bblur3_pkg.
module bblur3_line_store
    import bblur3_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [2*PIX_BITS-1:0]    rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [2*PIX_BITS-1:0]    wr_data
);

    logic [2*PIX_BITS-1:0] mem [DEPTH];
    logic [2*PIX_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a one-pixel-wide frame reads the column that is written in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/bblur3_lane.sv @@
// One colour channel of the blur: masked 3x3 sum, then rounded mean by a
// reciprocal multiply. Uses lane_ctrl_t and recip_of from bblur3_pkg.
module bblur3_lane
    import bblur3_pkg::*;
(
    input  logic                               aclk,
    input  lane_ctrl_t                         ctrl,
    input  logic [WIN_TAPS-1:0][CHAN_BITS-1:0] taps,
    output logic [CHAN_BITS-1:0]               mean
);

    localparam int NUM_BITS  = SUM_BITS + 1;
    localparam int PROD_BITS = NUM_BITS + RECIP_BITS;

    logic [SUM_BITS-1:0]  sum_next;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [NUM_BITS-1:0]  numer;
    logic [PROD_BITS-1:0] prod;
    logic [CHAN_BITS-1:0] mean_reg;

    always_comb begin
        sum_next = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            if (ctrl.take[i]) begin
                sum_next = sum_next + SUM_BITS'(taps[i]);
            end
        end
    end

    // floor((2*sum + n) / (2n)), n already registered alongside the sum
    assign numer = {sum_reg, 1'b0} + NUM_BITS'(ctrl.count);
    assign prod  = PROD_BITS'(numer) * PROD_BITS'(recip_of(ctrl.count));

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            sum_reg <= sum_next;
        end
        if (ctrl.out_en) begin
            mean_reg <= prod[RECIP_BITS +: CHAN_BITS];
        end
    end

    assign mean = mean_reg;

endmodule

@@ sv/box_blur_3x3_rgb.sv @@
// 3x3 box blur over an RGB pixel stream, mean of the in-frame neighbours.
// Uses bblur3_pkg, bblur3_line_store and three bblur3_lane instances.
//
// Usage:
//   s_tdata carries one pixel per item in raster order (red, green, blue from
//   the lowest byte up); s_tuser high marks a drain item. After the
//   width*height pixels of a frame the source sends width+1 drain items.
//   Output pixel k leaves on the item accepted as number k+width+1; items
//   before that give no result. m_tlast marks the last pixel of the frame.
//   The frame size is set through cfg_wr_*; a write restarts the stream and
//   holds s_tready low for one cycle while the pixel total is recomputed.
// Throughput: one item per clock when not stalled. The line store is read at
//   accept, written as it leaves stage 1; single-column frames use a bypass.
// Pipeline: an accepted item passes the line store read, then the window and
//   sums, then the multiply into the output register.
// Reset: frame size returns to 640 x 480 and the counters clear at once; the
//   line store is not cleared, as its stale entries only feed positions
//   outside the frame. No start-up sweep; s_tready rises in the cycle after
//   reset is released.
// Stall: while m_tvalid waits for m_tready the pipeline keeps taking items
//   that give no result and holds once a second result is waiting.
module box_blur_3x3_rgb
    import bblur3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic                     cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wr_data,
    // input pixels
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [PIX_BITS-1:0]      s_tdata,   // red_in, green_in, blue_in
    input  logic                     s_tuser,   // command
    // blurred pixels
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [PIX_BITS-1:0]      m_tdata,   // red_out, green_out, blue_out
    output logic                     m_tlast
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W > WIDTH_BITS) ? COL_W : WIDTH_BITS;

    // configuration, held in effective (saturated) form
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [ITEM_BITS-1:0]   total_reg;
    logic                   cfg_pend_reg;
    logic [WIDTH_BITS-1:0]  width_in;
    logic [HEIGHT_BITS-1:0] height_in;

    // stream position
    logic [ITEM_BITS-1:0]   items_reg,  items_next;
    logic [COL_W-1:0]       col_reg,    col_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [HEIGHT_BITS-1:0] out_row_reg, out_row_next;

    // accept-time decode
    logic                   accept;
    logic                   px_live;
    logic                   has_out;
    logic                   restart;
    logic                   col_wrap;
    logic                   out_col_wrap;
    logic                   out_row_last;
    logic [WIDTH_BITS-1:0]  width_m1;
    logic                   lo_c, hi_c, lo_r, hi_r;
    logic [1:0]             ncol, nrow;
    logic [WIN_TAPS-1:0]    take_next;

    // stage 1: line store read in flight
    logic                   s1_valid_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [PIX_BITS-1:0]    s1_px_reg;
    logic                   s1_has_reg;
    logic                   s1_last_reg;
    logic [WIN_TAPS-1:0]    s1_take_reg;
    logic [COUNT_BITS-1:0]  s1_count_reg;
    logic [2*PIX_BITS-1:0]  rows_rd;
    logic [PIX_BITS-1:0]    row_up, row_mid;

    // stage 2: lane sums registered
    logic                   s2_valid_reg;
    logic                   s2_has_reg;
    logic                   s2_last_reg;
    logic [COUNT_BITS-1:0]  s2_count_reg;

    // output register
    logic                   out_valid_reg;
    logic                   out_last_reg;

    logic                   out_free, s2_go, s1_go, mv1, mv2;

    logic [PIX_BITS-1:0]    win_reg  [WIN_TAPS];
    logic [PIX_BITS-1:0]    win_next [WIN_TAPS];

    lane_ctrl_t                                lane_ctrl;
    logic [LANES-1:0][WIN_TAPS-1:0][CHAN_BITS-1:0] lane_taps;
    logic [LANES-1:0][CHAN_BITS-1:0]               lane_mean;

    // ---------------- configuration ----------------
    always_comb begin
        width_in = cfg_wr_data[WIDTH_BITS-1:0];
        if (width_in == '0) begin
            width_in = WIDTH_BITS'(1);
        end else if (int'(width_in) > MAX_WIDTH) begin
            width_in = WIDTH_BITS'(MAX_WIDTH);
        end
        height_in = cfg_wr_data[HEIGHT_BITS-1:0];
        if (height_in == '0) begin
            height_in = HEIGHT_BITS'(1);
        end else if (int'(height_in) > HEIGHT_LIMIT) begin
            height_in = HEIGHT_BITS'(HEIGHT_LIMIT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= (int'(WIDTH_RESET) > MAX_WIDTH) ? WIDTH_BITS'(MAX_WIDTH)
                                                            : WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            cfg_pend_reg <= 1'b1;
        end else begin
            cfg_pend_reg <= cfg_wr_en;
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_FRAME_WIDTH:  width_reg  <= width_in;
                    REG_FRAME_HEIGHT: height_reg <= height_in;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= ITEM_BITS'(width_reg) * ITEM_BITS'(height_reg);
    end

    // ---------------- handshake ----------------
    assign out_free = !out_valid_reg || m_tready;
    assign s2_go    = !s2_valid_reg || !s2_has_reg || out_free;
    assign s1_go    = !s1_valid_reg || s2_go;
    assign mv1      = s1_valid_reg && s2_go;
    assign mv2      = s2_valid_reg && s2_has_reg && out_free;
    assign s_tready = s1_go && !cfg_pend_reg;
    assign accept   = s_tvalid && s_tready;

    // ---------------- position decode ----------------
    assign width_m1     = width_reg - WIDTH_BITS'(1);
    assign px_live      = !s_tuser && (items_reg < total_reg);
    assign has_out      = (items_reg >= ITEM_BITS'(width_reg) + ITEM_BITS'(1)) &&
                          ({1'b0, items_reg} <= {1'b0, total_reg} +
                                                (ITEM_BITS + 1)'(width_reg));
    assign restart      = {1'b0, items_reg} >= {1'b0, total_reg} +
                                               (ITEM_BITS + 1)'(width_reg);
    assign col_wrap     = CMP_W'(col_reg) == CMP_W'(width_m1);
    assign out_col_wrap = CMP_W'(out_col_reg) == CMP_W'(width_m1);
    assign out_row_last = out_row_reg == height_reg - HEIGHT_BITS'(1);

    assign lo_c = out_col_reg == '0;
    assign hi_c = out_col_wrap;
    assign lo_r = out_row_reg == '0;
    assign hi_r = out_row_last;
    assign ncol = 2'd3 - 2'(lo_c) - 2'(hi_c);
    assign nrow = 2'd3 - 2'(lo_r) - 2'(hi_r);

    // tap index is column*3 + row, column 0 the oldest, row 0 the upper row
    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            take_next[i] = !((i / 3 == 0 && lo_c) || (i / 3 == 2 && hi_c) ||
                             (i % 3 == 0 && lo_r) || (i % 3 == 2 && hi_r));
        end
    end

    always_comb begin
        items_next   = items_reg + ITEM_BITS'(1);
        col_next     = col_wrap ? '0 : col_reg + COL_W'(1);
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (has_out) begin
            out_col_next = out_col_wrap ? '0 : out_col_reg + COL_W'(1);
            out_row_next = out_col_wrap ? out_row_reg + HEIGHT_BITS'(1) : out_row_reg;
        end
        if (restart) begin
            items_next   = '0;
            col_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            items_reg   <= '0;
            col_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (cfg_wr_en) begin
            items_reg   <= '0;
            col_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (accept) begin
            items_reg   <= items_next;
            col_reg     <= col_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg   <= col_reg;
            s1_px_reg    <= px_live ? s_tdata : '0;
            s1_has_reg   <= has_out;
            s1_last_reg  <= out_col_wrap && out_row_last;
            s1_take_reg  <= take_next;
            s1_count_reg <= COUNT_BITS'(ncol) * COUNT_BITS'(nrow);
        end
    end

    bblur3_line_store #(
        .DEPTH   (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rows_rd),
        .wr_en   (mv1),
        .wr_addr (s1_col_reg),
        .wr_data ({row_mid, s1_px_reg})
    );

    assign row_up  = rows_rd[PIX_BITS +: PIX_BITS];
    assign row_mid = rows_rd[0 +: PIX_BITS];

    // ---------------- window ----------------
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win_next[i] = win_reg[i + 3];
        end
        win_next[6] = row_up;
        win_next[7] = row_mid;
        win_next[8] = s1_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            for (int i = 0; i < WIN_TAPS; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (mv1) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_go) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            s2_has_reg   <= s1_has_reg;
            s2_last_reg  <= s1_last_reg;
            s2_count_reg <= s1_count_reg;
        end
    end

    // ---------------- channel lanes ----------------
    assign lane_ctrl.sum_en = mv1;
    assign lane_ctrl.out_en = mv2;
    assign lane_ctrl.take   = s1_take_reg;
    assign lane_ctrl.count  = s2_count_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        for (genvar i = 0; i < WIN_TAPS; i++) begin : g_tap
            assign lane_taps[l][i] = win_next[i][l*CHAN_BITS +: CHAN_BITS];
        end

        bblur3_lane u_lane (
            .aclk (aclk),
            .ctrl (lane_ctrl),
            .taps (lane_taps[l]),
            .mean (lane_mean[l])
        );
    end

    // ---------------- merge and output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mv2) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv2) begin
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lane_mean;
    assign m_tlast  = out_last_reg;

endmodule
